/* hw/rtl/assert_macros.svh */
// assertion macros for the rtl of the periodic event table
// each macro expects signals named clk and rst in the using module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define PET_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define PET_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/pet_pkg.sv */
// package for the periodic event table: sizes, codes and item types
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pet_pkg;

  localparam int SLOTS  = 16;
  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);

  localparam int TIME_W   = 48;
  localparam int PERIOD_W = 32;
  localparam int LEAD_W   = 20;
  localparam logic [LEAD_W-1:0] LEAD_RESET = 20'd1000;

  localparam logic [2:0] OP_ADD    = 3'd0;
  localparam logic [2:0] OP_CHANGE = 3'd1;
  localparam logic [2:0] OP_RESET  = 3'd2;
  localparam logic [2:0] OP_REMOVE = 3'd3;
  localparam logic [2:0] OP_SCAN   = 3'd4;

  localparam logic [1:0] KIND_FIRED   = 2'd0;
  localparam logic [1:0] KIND_ACK     = 2'd1;
  localparam logic [1:0] KIND_FULL    = 2'd2;
  localparam logic [1:0] KIND_NOENTRY = 2'd3;

  typedef struct packed {
    logic [2:0]          op;
    logic [3:0]          slot;
    logic [PERIOD_W-1:0] interval;
    logic [TIME_W-1:0]   now;
  } pet_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] slot_out;
    logic       last;
  } pet_result_t;

  // verdict of the fire check for one slot
  typedef struct packed {
    logic              fire;
    logic [TIME_W-1:0] next_last;
  } pet_fire_t;

endpackage

`default_nettype wire

/* hw/rtl/pet_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module pet_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                          clk,
  input  wire logic                                          we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  wire logic [WIDTH-1:0]                              wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic      [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hw/rtl/pet_fire_calc.sv */
// fire check for one slot: elapsed time against period, and the advanced last time
// depends on pet_pkg
`timescale 1ns / 1ps
`default_nettype none

module pet_fire_calc (
  input  wire logic [pet_pkg::TIME_W-1:0]   now,
  input  wire logic [pet_pkg::TIME_W-1:0]   prev_time,
  input  wire logic [pet_pkg::PERIOD_W-1:0] period,
  output pet_pkg::pet_fire_t                verdict
);

  logic [pet_pkg::TIME_W-1:0] elapsed;

  // differences wrap at the time width
  assign elapsed           = now - prev_time;
  assign verdict.fire      = elapsed > pet_pkg::TIME_W'(period);
  assign verdict.next_last = prev_time + pet_pkg::TIME_W'(period);

endmodule

`default_nettype wire

/* hw/rtl/periodic_event_table.sv */
// top level of the periodic event table: command decode, slot flags, scan sequencer
// depends on pet_pkg, pet_ram, pet_fire_calc and assert_macros.svh
//
// usage:
//   an item (op, slot, interval, now) is taken at a clock edge with start high and
//   busy low. results come out on result, one per cycle, each marked by strobe for
//   exactly one cycle; the receiver cannot stall them. result.last marks the final
//   result of an item.
//   add, change, reset and remove give a single result that shows in the cycle
//   after the item is taken; busy stays low, so such items can be given every
//   cycle. unused op codes give no result.
//   a scan holds busy high until its done result shows: the timer
//   memories are read one slot per cycle through their single read port, each
//   read is checked and written back in the next cycle, and a done result
//   follows the last slot. fired results are registered from that check.
//   lead is written through cfg_we / cfg_wdata; the user must do so only while idle,
//   the block does not enforce it. reset clears every in-use flag and sets the lead
//   to 1000; timer memories need no clearing, slots are acted on only while in use.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module periodic_event_table (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire pet_pkg::pet_item_t           item,
  input  wire logic                         cfg_we,
  input  wire logic [pet_pkg::LEAD_W-1:0]   cfg_wdata,
  output logic                              strobe,
  output pet_pkg::pet_result_t              result
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t                           state;
  logic [pet_pkg::SLOTS-1:0]        in_use;
  logic [pet_pkg::LEAD_W-1:0]       lead;
  logic [pet_pkg::TIME_W-1:0]       scan_now;
  logic [pet_pkg::CNT_W-1:0]        rd_idx;
  logic                             pipe_v;
  logic [pet_pkg::SLOT_W-1:0]       pipe_idx;

  logic                             accept;
  logic                             free_found;
  logic [pet_pkg::SLOT_W-1:0]       free_idx;
  logic [pet_pkg::SLOT_W-1:0]       slot_idx;
  logic                             slot_hit;
  logic                             rd_issue;
  logic                             scan_fire;
  logic [pet_pkg::TIME_W-1:0]       add_last;

  logic                             lft_we;
  logic [pet_pkg::SLOT_W-1:0]       lft_waddr;
  logic [pet_pkg::TIME_W-1:0]       lft_wdata;
  logic [pet_pkg::TIME_W-1:0]       lft_rdata;
  logic                             per_we;
  logic [pet_pkg::SLOT_W-1:0]       per_waddr;
  logic [pet_pkg::PERIOD_W-1:0]     per_rdata;
  pet_pkg::pet_fire_t               verdict;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // lowest free slot
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = pet_pkg::SLOTS - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        free_found = 1'b1;
        free_idx   = pet_pkg::SLOT_W'(i);
      end
    end
  end

  assign slot_idx = pet_pkg::SLOT_W'(item.slot);
  assign slot_hit = (32'(item.slot) < pet_pkg::SLOTS) && in_use[slot_idx];
  assign add_last = item.now - pet_pkg::TIME_W'(item.interval)
                  - pet_pkg::TIME_W'(lead);
  assign rd_issue = (state == S_SCAN) && (rd_idx < pet_pkg::CNT_W'(pet_pkg::SLOTS));
  assign scan_fire = (state == S_SCAN) && pipe_v && in_use[pipe_idx] && verdict.fire;

  // write port selection; scan writes never meet command writes
  always_comb begin
    lft_we    = 1'b0;
    lft_waddr = free_idx;
    lft_wdata = add_last;
    if (scan_fire) begin
      lft_we    = 1'b1;
      lft_waddr = pipe_idx;
      lft_wdata = verdict.next_last;
    end else if (accept && item.op == pet_pkg::OP_ADD && free_found) begin
      lft_we    = 1'b1;
    end else if (accept && item.op == pet_pkg::OP_RESET && slot_hit) begin
      lft_we    = 1'b1;
      lft_waddr = slot_idx;
      lft_wdata = item.now;
    end
  end

  always_comb begin
    per_we    = 1'b0;
    per_waddr = free_idx;
    if (accept && item.op == pet_pkg::OP_ADD && free_found) begin
      per_we    = 1'b1;
    end else if (accept && item.op == pet_pkg::OP_CHANGE && slot_hit) begin
      per_we    = 1'b1;
      per_waddr = slot_idx;
    end
  end

  pet_ram #(
    .WIDTH (pet_pkg::TIME_W),
    .DEPTH (pet_pkg::SLOTS)
  ) u_last_ram (
    .clk   (clk),
    .we    (lft_we),
    .waddr (lft_waddr),
    .wdata (lft_wdata),
    .raddr (rd_idx[pet_pkg::SLOT_W-1:0]),
    .rdata (lft_rdata)
  );

  pet_ram #(
    .WIDTH (pet_pkg::PERIOD_W),
    .DEPTH (pet_pkg::SLOTS)
  ) u_period_ram (
    .clk   (clk),
    .we    (per_we),
    .waddr (per_waddr),
    .wdata (item.interval),
    .raddr (rd_idx[pet_pkg::SLOT_W-1:0]),
    .rdata (per_rdata)
  );

  pet_fire_calc u_fire (
    .now       (scan_now),
    .prev_time (lft_rdata),
    .period    (per_rdata),
    .verdict   (verdict)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      strobe <= 1'b0;
      in_use <= '0;
      lead   <= pet_pkg::LEAD_RESET;
      rd_idx <= '0;
      pipe_v <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (cfg_we) begin
        lead <= cfg_wdata;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (item.op) inside
              pet_pkg::OP_ADD: begin
                strobe <= 1'b1;
                if (free_found) begin
                  in_use[free_idx] <= 1'b1;
                  result <= '{kind: pet_pkg::KIND_ACK, slot_out: 4'(free_idx), last: 1'b1};
                end else begin
                  result <= '{kind: pet_pkg::KIND_FULL, slot_out: 4'd0, last: 1'b1};
                end
              end
              pet_pkg::OP_CHANGE, pet_pkg::OP_RESET, pet_pkg::OP_REMOVE: begin
                strobe <= 1'b1;
                if (slot_hit) begin
                  if (item.op == pet_pkg::OP_REMOVE) begin
                    in_use[slot_idx] <= 1'b0;
                  end
                  result <= '{kind: pet_pkg::KIND_ACK, slot_out: item.slot, last: 1'b1};
                end else begin
                  result <= '{kind: pet_pkg::KIND_NOENTRY, slot_out: item.slot, last: 1'b1};
                end
              end
              pet_pkg::OP_SCAN: begin
                state    <= S_SCAN;
                scan_now <= item.now;
                rd_idx   <= '0;
                pipe_v   <= 1'b0;
              end
              default: begin
              end
            endcase
          end
        end
        S_SCAN: begin
          // read of slot rd_idx overlaps check and write-back of pipe_idx
          pipe_v   <= rd_issue;
          pipe_idx <= rd_idx[pet_pkg::SLOT_W-1:0];
          if (rd_issue) begin
            rd_idx <= rd_idx + 1'b1;
          end
          if (scan_fire) begin
            strobe <= 1'b1;
            result <= '{kind: pet_pkg::KIND_FIRED, slot_out: 4'(pipe_idx), last: 1'b0};
          end
          if (pipe_v && pipe_idx == pet_pkg::SLOT_W'(pet_pkg::SLOTS - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          strobe <= 1'b1;
          result <= '{kind: pet_pkg::KIND_ACK, slot_out: 4'd0, last: 1'b1};
          state  <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `PET_ASSERT(a_fired_in_scan,
    strobe && result.kind == pet_pkg::KIND_FIRED |-> busy && !result.last,
    "fired result outside a scan")
  `PET_ASSERT(a_final_idle,
    strobe && result.last |-> !busy,
    "final result while still busy")
  `PET_ASSERT(a_last_write_src,
    lft_we |-> (state == S_SCAN && pipe_v) || accept,
    "timer memory written without a scan step or a command")

endmodule

`default_nettype wire
